// File: hw/rtl/mlfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Sizes, request and status codes, and the command and status bundles that
// pass between the scheduler controller and its datapath.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // Table sizes.
  localparam int MAX_THREADS = 16;
  localparam int LEVELS      = 4;

  // Internal widths derived from the table sizes.
  localparam int THR_W  = $clog2(MAX_THREADS);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam int ADDR_W = $clog2(LEVELS * MAX_THREADS);

  // Port field widths.
  localparam int REQ_W    = 3;
  localparam int THREAD_W = 4;
  localparam int LEVEL_W  = 2;
  localparam int ERR_W    = 2;
  localparam int SWITCH_W = 32;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 3'd0,
    REQ_TICK   = 3'd1,
    REQ_YIELD  = 3'd2,
    REQ_BLOCK  = 3'd3,
    REQ_WAKE   = 3'd4,
    REQ_EXIT   = 3'd5
  } req_e;

  // Error codes.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE = 2'd0,
    ERR_FULL = 2'd1,
    ERR_WAKE = 2'd2
  } err_e;

  // Per-thread status codes.
  typedef enum logic [1:0] {
    TS_UNUSED   = 2'd0,
    TS_READY    = 2'd1,
    TS_BLOCKED  = 2'd2,
    TS_FINISHED = 2'd3
  } thr_state_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CREATE,
    OP_PROMOTE,
    OP_REQUEUE,
    OP_BLOCK,
    OP_EXIT,
    OP_WAKE,
    OP_POP,
    OP_LOAD,
    OP_DEMOTE
  } dp_op_e;

  // Controller to datapath.
  typedef struct packed {
    dp_op_e op;
    logic   capture;
    logic   load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    req_e req;
    logic any_ready;
  } dp_status_t;

endpackage

// File: hw/rtl/mlfq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ scheduler datapath
// Holds the per-level thread FIFOs, the thread tables, the running thread,
// the switch counter and the result register. Executes one operation per
// cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module mlfq_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mlfq_pkg::dp_cmd_t              cmd_i,
  output mlfq_pkg::dp_status_t           status_o,
  input  logic [mlfq_pkg::REQ_W-1:0]     req_type_i,
  input  logic [mlfq_pkg::THREAD_W-1:0]  target_thread_i,
  output logic                           running_valid_o,
  output logic [mlfq_pkg::THREAD_W-1:0]  running_thread_o,
  output logic [mlfq_pkg::LEVEL_W-1:0]   running_level_o,
  output logic [mlfq_pkg::THREAD_W-1:0]  created_thread_o,
  output logic [mlfq_pkg::ERR_W-1:0]     error_code_o,
  output logic [mlfq_pkg::SWITCH_W-1:0]  switch_total_o
);

  // Captured transaction.
  logic [mlfq_pkg::REQ_W-1:0]    req_q;
  logic [mlfq_pkg::THREAD_W-1:0] tgt_q;

  // Scheduler state.
  logic [mlfq_pkg::THR_W-1:0] queue_head_q [mlfq_pkg::LEVELS];
  logic [mlfq_pkg::THR_W-1:0] queue_head_d [mlfq_pkg::LEVELS];
  logic [mlfq_pkg::CNT_W-1:0] queue_fill_q [mlfq_pkg::LEVELS];
  logic [mlfq_pkg::CNT_W-1:0] queue_fill_d [mlfq_pkg::LEVELS];
  logic [mlfq_pkg::LVL_W-1:0] thread_level_q [mlfq_pkg::MAX_THREADS];
  logic [mlfq_pkg::LVL_W-1:0] thread_level_d [mlfq_pkg::MAX_THREADS];
  mlfq_pkg::thr_state_e       thread_state_q [mlfq_pkg::MAX_THREADS];
  mlfq_pkg::thr_state_e       thread_state_d [mlfq_pkg::MAX_THREADS];
  logic [mlfq_pkg::CNT_W-1:0]    next_q, next_d;
  logic [mlfq_pkg::THR_W-1:0]    cur_q, cur_d;
  logic                          cur_valid_q, cur_valid_d;
  logic [mlfq_pkg::SWITCH_W-1:0] switch_q, switch_d;
  logic [mlfq_pkg::THREAD_W-1:0] created_q, created_d;
  mlfq_pkg::err_e                err_q, err_d;

  // FIFO storage, one row of MAX_THREADS entries per level.
  logic [mlfq_pkg::THR_W-1:0] level_queue [mlfq_pkg::LEVELS * mlfq_pkg::MAX_THREADS];
  logic [mlfq_pkg::THR_W-1:0] rd_data_q;

  // Result register.
  logic                          res_valid_q;
  logic [mlfq_pkg::THREAD_W-1:0] res_thread_q;
  logic [mlfq_pkg::LEVEL_W-1:0]  res_level_q;
  logic [mlfq_pkg::THREAD_W-1:0] res_created_q;
  logic [mlfq_pkg::ERR_W-1:0]    res_err_q;
  logic [mlfq_pkg::SWITCH_W-1:0] res_switch_q;

  logic [mlfq_pkg::THR_W-1:0] tgt_idx;
  logic                       tgt_in_range;
  logic [mlfq_pkg::THR_W-1:0] idx;
  logic [mlfq_pkg::LVL_W-1:0] lvl_rd;
  mlfq_pkg::thr_state_e       st_rd;
  logic                       wake_ok;

  logic                        push_req;
  logic                        wr_en;
  logic [mlfq_pkg::LVL_W-1:0]  push_lvl;
  logic [mlfq_pkg::THR_W-1:0]  push_thr;
  logic [mlfq_pkg::CNT_W:0]    slot_sum;
  logic [mlfq_pkg::THR_W-1:0]  slot;
  logic [mlfq_pkg::ADDR_W-1:0] wr_addr;

  logic                        any_ready;
  logic [mlfq_pkg::LVL_W-1:0]  sel_lvl;
  logic [mlfq_pkg::ADDR_W-1:0] rd_addr;
  logic                        rd_en;

  // Single thread table read port: the wake target during a wake, else the running thread.
  assign tgt_idx      = mlfq_pkg::THR_W'(tgt_q);
  assign tgt_in_range = (32'(tgt_q) < mlfq_pkg::MAX_THREADS);
  assign idx          = (cmd_i.op == mlfq_pkg::OP_WAKE) ? tgt_idx : cur_q;
  assign lvl_rd       = thread_level_q[idx];
  assign st_rd        = thread_state_q[idx];
  assign wake_ok      = tgt_in_range && (st_rd == mlfq_pkg::TS_BLOCKED);

  // Push source selection for create, requeue and wake.
  always_comb begin
    push_req = 1'b0;
    push_lvl = '0;
    push_thr = '0;
    case (cmd_i.op)
      mlfq_pkg::OP_CREATE: begin
        push_req = (next_q < mlfq_pkg::CNT_W'(mlfq_pkg::MAX_THREADS));
        push_thr = mlfq_pkg::THR_W'(next_q);
      end
      mlfq_pkg::OP_REQUEUE: begin
        push_req = cur_valid_q;
        push_lvl = lvl_rd;
        push_thr = cur_q;
      end
      mlfq_pkg::OP_WAKE: begin
        push_req = wake_ok;
        push_lvl = lvl_rd;
        push_thr = tgt_idx;
      end
      default: ;
    endcase
  end

  // Tail slot of the pushed level; head plus fill stays below twice the depth.
  assign slot_sum = (mlfq_pkg::CNT_W+1)'(queue_head_q[push_lvl])
                  + (mlfq_pkg::CNT_W+1)'(queue_fill_q[push_lvl]);
  assign slot     = (slot_sum >= (mlfq_pkg::CNT_W+1)'(mlfq_pkg::MAX_THREADS))
                  ? mlfq_pkg::THR_W'(slot_sum - (mlfq_pkg::CNT_W+1)'(mlfq_pkg::MAX_THREADS))
                  : mlfq_pkg::THR_W'(slot_sum);
  assign wr_addr  = mlfq_pkg::ADDR_W'(mlfq_pkg::ADDR_W'(push_lvl)
                  * mlfq_pkg::ADDR_W'(mlfq_pkg::MAX_THREADS) + mlfq_pkg::ADDR_W'(slot));
  assign wr_en    = push_req
                  && (queue_fill_q[push_lvl] < mlfq_pkg::CNT_W'(mlfq_pkg::MAX_THREADS));

  // Fixed priority encoder: lowest non-empty level wins.
  always_comb begin
    any_ready = 1'b0;
    sel_lvl   = '0;
    for (int l = mlfq_pkg::LEVELS - 1; l >= 0; l--) begin
      if (queue_fill_q[l] != '0) begin
        any_ready = 1'b1;
        sel_lvl   = mlfq_pkg::LVL_W'(l);
      end
    end
  end

  assign rd_en   = (cmd_i.op == mlfq_pkg::OP_POP);
  assign rd_addr = mlfq_pkg::ADDR_W'(mlfq_pkg::ADDR_W'(sel_lvl)
                 * mlfq_pkg::ADDR_W'(mlfq_pkg::MAX_THREADS)
                 + mlfq_pkg::ADDR_W'(queue_head_q[sel_lvl]));

  assign status_o.req       = mlfq_pkg::req_e'(req_q);
  assign status_o.any_ready = any_ready;

  // Next-state logic for the scheduler tables.
  always_comb begin
    queue_head_d   = queue_head_q;
    queue_fill_d   = queue_fill_q;
    thread_level_d = thread_level_q;
    thread_state_d = thread_state_q;
    next_d         = next_q;
    cur_d          = cur_q;
    cur_valid_d    = cur_valid_q;
    switch_d       = switch_q;
    created_d      = created_q;
    err_d          = err_q;

    if (cmd_i.capture) begin
      created_d = '0;
      err_d     = mlfq_pkg::ERR_NONE;
    end

    // FIFO bookkeeping.
    for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
      if (wr_en && (push_lvl == mlfq_pkg::LVL_W'(l))) begin
        queue_fill_d[l] = queue_fill_q[l] + 1'b1;
      end
      if (rd_en && (sel_lvl == mlfq_pkg::LVL_W'(l))) begin
        queue_head_d[l] = (queue_head_q[l] == mlfq_pkg::THR_W'(mlfq_pkg::MAX_THREADS - 1))
                        ? '0 : queue_head_q[l] + 1'b1;
        queue_fill_d[l] = queue_fill_q[l] - 1'b1;
      end
    end

    case (cmd_i.op)
      mlfq_pkg::OP_CREATE: begin
        if (next_q < mlfq_pkg::CNT_W'(mlfq_pkg::MAX_THREADS)) begin
          thread_state_d[mlfq_pkg::THR_W'(next_q)] = mlfq_pkg::TS_READY;
          thread_level_d[mlfq_pkg::THR_W'(next_q)] = '0;
          created_d = mlfq_pkg::THREAD_W'(next_q);
          next_d    = next_q + 1'b1;
        end else begin
          err_d = mlfq_pkg::ERR_FULL;
        end
      end
      mlfq_pkg::OP_PROMOTE: begin
        if (cur_valid_q && (lvl_rd != '0)) begin
          thread_level_d[cur_q] = lvl_rd - 1'b1;
        end
      end
      mlfq_pkg::OP_REQUEUE: begin
        cur_valid_d = 1'b0;
      end
      mlfq_pkg::OP_BLOCK: begin
        if (cur_valid_q) begin
          thread_state_d[cur_q] = mlfq_pkg::TS_BLOCKED;
          cur_valid_d = 1'b0;
        end
      end
      mlfq_pkg::OP_EXIT: begin
        if (cur_valid_q) begin
          thread_state_d[cur_q] = mlfq_pkg::TS_FINISHED;
          cur_valid_d = 1'b0;
        end
      end
      mlfq_pkg::OP_WAKE: begin
        if (wake_ok) begin
          thread_state_d[tgt_idx] = mlfq_pkg::TS_READY;
        end else begin
          err_d = mlfq_pkg::ERR_WAKE;
        end
      end
      mlfq_pkg::OP_LOAD: begin
        cur_d       = rd_data_q;
        cur_valid_d = 1'b1;
        switch_d    = switch_q + 1'b1;
      end
      mlfq_pkg::OP_DEMOTE: begin
        if (lvl_rd != mlfq_pkg::LVL_W'(mlfq_pkg::LEVELS - 1)) begin
          thread_level_d[cur_q] = lvl_rd + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Scheduler state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        queue_head_q[l] <= '0;
        queue_fill_q[l] <= '0;
      end
      for (int t = 0; t < mlfq_pkg::MAX_THREADS; t++) begin
        thread_level_q[t] <= '0;
        thread_state_q[t] <= mlfq_pkg::TS_UNUSED;
      end
      next_q      <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      switch_q    <= '0;
      created_q   <= '0;
      err_q       <= mlfq_pkg::ERR_NONE;
    end else begin
      queue_head_q   <= queue_head_d;
      queue_fill_q   <= queue_fill_d;
      thread_level_q <= thread_level_d;
      thread_state_q <= thread_state_d;
      next_q         <= next_d;
      cur_q          <= cur_d;
      cur_valid_q    <= cur_valid_d;
      switch_q       <= switch_d;
      created_q      <= created_d;
      err_q          <= err_d;
    end
  end

  // FIFO storage: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      level_queue[wr_addr] <= push_thr;
    end
    if (rd_en) begin
      rd_data_q <= level_queue[rd_addr];
    end
  end

  // Transaction capture and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      tgt_q <= target_thread_i;
    end
    if (cmd_i.load_out) begin
      res_valid_q   <= cur_valid_q;
      res_thread_q  <= cur_valid_q ? mlfq_pkg::THREAD_W'(cur_q) : '0;
      res_level_q   <= cur_valid_q ? mlfq_pkg::LEVEL_W'(lvl_rd) : '0;
      res_created_q <= created_q;
      res_err_q     <= err_q;
      res_switch_q  <= switch_q;
    end
  end

  assign running_valid_o  = res_valid_q;
  assign running_thread_o = res_thread_q;
  assign running_level_o  = res_level_q;
  assign created_thread_o = res_created_q;
  assign error_code_o     = res_err_q;
  assign switch_total_o   = res_switch_q;

  // A pop is only issued when some level holds a thread.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == mlfq_pkg::OP_POP) |-> any_ready)
    else $error("pop issued with all levels empty");

  // Loading a popped thread always leaves a thread running.
  a_load_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == mlfq_pkg::OP_LOAD) |=> cur_valid_q)
    else $error("no running thread after load");

  // The switch counter moves only on a load.
  a_switch_only_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op != mlfq_pkg::OP_LOAD) |=> $stable(switch_q))
    else $error("switch counter changed without a load");

endmodule

// File: hw/rtl/mlfq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ scheduler controller
// Sequences each accepted request into datapath operations and manages the
// input and output handshakes.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mlfq_pkg::dp_cmd_t    cmd_o,
  input  mlfq_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REQUEUE,
    S_SELECT,
    S_LOAD,
    S_DEMOTE,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Next state and datapath command.
  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q;
    cmd_o.op       = mlfq_pkg::OP_NONE;
    cmd_o.capture  = 1'b0;
    cmd_o.load_out = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESULT;
        unique case (status_i.req)
          mlfq_pkg::REQ_CREATE: cmd_o.op = mlfq_pkg::OP_CREATE;
          mlfq_pkg::REQ_TICK:   state_d  = S_REQUEUE;
          mlfq_pkg::REQ_YIELD: begin
            cmd_o.op = mlfq_pkg::OP_PROMOTE;
            state_d  = S_REQUEUE;
          end
          mlfq_pkg::REQ_BLOCK:  cmd_o.op = mlfq_pkg::OP_BLOCK;
          mlfq_pkg::REQ_WAKE:   cmd_o.op = mlfq_pkg::OP_WAKE;
          mlfq_pkg::REQ_EXIT:   cmd_o.op = mlfq_pkg::OP_EXIT;
          default: ;
        endcase
      end
      S_REQUEUE: begin
        cmd_o.op = mlfq_pkg::OP_REQUEUE;
        state_d  = S_SELECT;
      end
      S_SELECT: begin
        if (status_i.any_ready) begin
          cmd_o.op = mlfq_pkg::OP_POP;
          state_d  = S_LOAD;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_LOAD: begin
        cmd_o.op = mlfq_pkg::OP_LOAD;
        state_d  = S_DEMOTE;
      end
      S_DEMOTE: begin
        cmd_o.op = mlfq_pkg::OP_DEMOTE;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted transaction always starts execution next.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted transaction did not start");

  // A result with a free output register is presented and the block returns to idle.
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && out_free) |=> (state_q == S_IDLE && out_valid_q))
    else $error("result not presented");

  // With every level empty, selection goes straight to the result.
  a_select_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SELECT && !status_i.any_ready) |=> (state_q == S_RESULT))
    else $error("selection ran with empty levels");

endmodule

// File: hw/rtl/mlfq_thread_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLFQ thread scheduler core
// Multilevel feedback queue scheduler with per-level FIFOs of thread numbers.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries one request per
//   transaction: req_type_i and target_thread_i. The output channel
//   (out_valid_o/out_ready_i) returns exactly one result per request: the
//   running thread and its level, the created thread number, an error code
//   and the context switch total.
//   Create, block, wake, exit and unknown requests pass through an
//   execute step and then the result step, where the result is
//   registered. A tick or yield that dispatches a thread is sequenced
//   through requeue, level select, a registered FIFO memory read, load
//   and demotion before its result step. A tick or yield that finds every
//   level empty skips the read, load and demotion. One request is in
//   flight at a time: a new request is accepted only once the current
//   one has left its result step.
//   The result sits in an output register: the next request is accepted
//   while a result waits, and a stalled receiver only holds the following
//   request at its result step.
//   Reset clears the FIFO pointers, thread tables, running thread and
//   switch counter at once; the FIFO storage itself needs no clearing.
// ----------------------------------------------------------------------------
module mlfq_thread_scheduler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mlfq_pkg::REQ_W-1:0]    req_type_i,
  input  logic [mlfq_pkg::THREAD_W-1:0] target_thread_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          running_valid_o,
  output logic [mlfq_pkg::THREAD_W-1:0] running_thread_o,
  output logic [mlfq_pkg::LEVEL_W-1:0]  running_level_o,
  output logic [mlfq_pkg::THREAD_W-1:0] created_thread_o,
  output logic [mlfq_pkg::ERR_W-1:0]    error_code_o,
  output logic [mlfq_pkg::SWITCH_W-1:0] switch_total_o
);

  mlfq_pkg::dp_cmd_t    dp_cmd;
  mlfq_pkg::dp_status_t dp_status;

  // Request sequencer.
  mlfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  // Queues, tables and result register.
  mlfq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .status_o         (dp_status),
    .req_type_i       (req_type_i),
    .target_thread_i  (target_thread_i),
    .running_valid_o  (running_valid_o),
    .running_thread_o (running_thread_o),
    .running_level_o  (running_level_o),
    .created_thread_o (created_thread_o),
    .error_code_o     (error_code_o),
    .switch_total_o   (switch_total_o)
  );

endmodule
